[rtl/core/gcd_pkg.sv]
// Shared constants, types and the arctangent table for the great-circle distance pipeline.
// Used by every module in rtl/core; depends on nothing else.
package gcd_pkg;

   localparam int CORDIC_STEPS = 32;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int CW           = 36;   // CORDIC datapath width, Q2.30 with headroom
   localparam int DW           = 34;   // angle width in half units of 1e-7 degree
   localparam int SQRT_BITS    = 31;   // root width, roots reach 2^30 exactly
   localparam int SQRT_IW      = $clog2(SQRT_BITS);
   localparam int RW           = 2 * SQRT_BITS - 1;

   localparam logic [63:0] PI_Q62       = 64'hC90FDAA22168C234;
   localparam logic [63:0] PI_Q30       = 64'hC90FDAA2;
   localparam logic [63:0] RAD_SCALE    = (PI_Q62 + 64'd1800000000) / 64'd3600000000;
   localparam logic [63:0] RADIUS_CM    = 64'd637100000;
   localparam logic [63:0] HALF_CIRC_CM = (RADIUS_CM * PI_Q30 + 64'd536870912) >> 30;

   localparam logic signed [DW-1:0] QUARTER_TURN = DW'(64'sd1800000000);
   localparam logic signed [DW-1:0] HALF_TURN    = DW'(64'sd3600000000);
   localparam logic signed [CW-1:0] CORDIC_GAIN  = CW'(64'sd652032874);
   localparam logic [30:0]          ONE_Q30      = 31'd1073741824;

   typedef enum logic {
      CORDIC_ROTATE,
      CORDIC_VECTOR
   } cordic_mode_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_vec_type;

   typedef struct packed {
      logic [RW-1:0]        rem;
      logic [SQRT_BITS-1:0] root;
   } sqrt_state_type;

   // Elementary angles atan(2^-i) in Q2.30; beyond the head the small-angle value is exact.
   function automatic logic signed [CW-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [CW-1:0] r;
      case (i)
         STEP_W'(0): r = CW'(843314857);
         STEP_W'(1): r = CW'(497837829);
         STEP_W'(2): r = CW'(263043837);
         STEP_W'(3): r = CW'(133525159);
         STEP_W'(4): r = CW'(67021687);
         STEP_W'(5): r = CW'(33543516);
         STEP_W'(6): r = CW'(16775851);
         STEP_W'(7): r = CW'(8388437);
         STEP_W'(8): r = CW'(4194283);
         STEP_W'(9): r = CW'(2097149);
         default: begin
            if (int'(i) <= 30) begin
               r = CW'(1) <<< (30 - int'(i));
            end else begin
               r = '0;
            end
         end
      endcase
      return r;
   endfunction

endpackage

[rtl/core/gcd_angle.sv]
// Angle front end: folds an angle into a quarter turn either side of zero and scales it to
// Q2.30 radians over three registered stages. Depends on gcd_pkg.
module gcd_angle (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [gcd_pkg::DW-1:0] angle,
   output logic signed [gcd_pkg::CW-1:0] rad,
   output logic                         flip
);

   logic signed [gcd_pkg::DW-1:0] folded;
   logic [30:0]                   mag_ff, mag_in;
   logic                          neg1_ff, neg1_in, flip1_ff, flip1_in;
   logic [62:0]                   prod_ff, prod_in;
   logic                          neg2_ff, flip2_ff;
   logic [30:0]                   round_mag;
   logic signed [gcd_pkg::CW-1:0] rad_ff, rad_in;
   logic                          flip3_ff;

   always_comb begin
      folded   = angle;
      flip1_in = 1'b0;
      if (angle > gcd_pkg::QUARTER_TURN) begin
         folded   = angle - gcd_pkg::HALF_TURN;
         flip1_in = 1'b1;
      end else if (angle < -gcd_pkg::QUARTER_TURN) begin
         folded   = angle + gcd_pkg::HALF_TURN;
         flip1_in = 1'b1;
      end
      neg1_in   = folded[gcd_pkg::DW-1];
      mag_in    = 31'(neg1_in ? -folded : folded);
      prod_in   = 63'(mag_ff) * 63'(gcd_pkg::RAD_SCALE[31:0]);
      round_mag = 31'((prod_ff + (63'(1) << 31)) >> 32);
      rad_in    = neg2_ff ? -gcd_pkg::CW'(round_mag) : gcd_pkg::CW'(round_mag);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff   <= mag_in;
         neg1_ff  <= neg1_in;
         flip1_ff <= flip1_in;
         prod_ff  <= prod_in;
         neg2_ff  <= neg1_ff;
         flip2_ff <= flip1_ff;
         rad_ff   <= rad_in;
         flip3_ff <= flip2_ff;
      end
   end

   assign rad  = rad_ff;
   assign flip = flip3_ff;

endmodule

[rtl/core/gcd_cordic_cell.sv]
// One CORDIC micro-rotation with its output register, in rotation or vectoring mode.
// Depends on gcd_pkg for the vector type and the arctangent table.
module gcd_cordic_cell (
   input  logic                            clock,
   input  logic                            enable,
   input  gcd_pkg::cordic_mode_type        mode,
   input  logic [gcd_pkg::STEP_W-1:0]      step,
   input  gcd_pkg::cordic_vec_type         prev_vec,
   output gcd_pkg::cordic_vec_type         vec
);

   gcd_pkg::cordic_vec_type       vec_ff, vec_in;
   logic                          clockwise;
   logic signed [gcd_pkg::CW-1:0] x_shift, y_shift, angle;

   always_comb begin
      clockwise = (mode == gcd_pkg::CORDIC_ROTATE) ? prev_vec.z[gcd_pkg::CW-1]
                                                   : !prev_vec.y[gcd_pkg::CW-1];
      x_shift   = prev_vec.x >>> step;
      y_shift   = prev_vec.y >>> step;
      angle     = gcd_pkg::atan_entry(step);
      if (clockwise) begin
         vec_in.x = prev_vec.x + y_shift;
         vec_in.y = prev_vec.y - x_shift;
         vec_in.z = prev_vec.z + angle;
      end else begin
         vec_in.x = prev_vec.x - y_shift;
         vec_in.y = prev_vec.y + x_shift;
         vec_in.z = prev_vec.z - angle;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in;
      end
   end

   assign vec = vec_ff;

endmodule

[rtl/core/gcd_sqrt_cell.sv]
// One digit of a restoring square root: decides a single root bit and registers the result.
// Depends on gcd_pkg for the root state type.
module gcd_sqrt_cell (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [gcd_pkg::SQRT_IW-1:0] step,
   input  gcd_pkg::sqrt_state_type     prev_state,
   output gcd_pkg::sqrt_state_type     state
);

   gcd_pkg::sqrt_state_type state_ff, state_in;
   logic [63:0]             delta;

   // Setting bit k of the root adds 2^(k+1)*root + 2^(2k) to its square.
   always_comb begin
      delta    = (64'(prev_state.root) << (step + 1)) + (64'd1 << (2 * step));
      state_in = prev_state;
      if (64'(prev_state.rem) >= delta) begin
         state_in.rem  = gcd_pkg::RW'(64'(prev_state.rem) - delta);
         state_in.root = prev_state.root | (gcd_pkg::SQRT_BITS'(1) << step);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

[rtl/core/great_circle_distance.sv]
// Haversine great-circle distance, one position pair in and one distance in centimetres out.
// It runs through two CORDIC cell rows and two 31-cell square-root rows, taking one beat per
// cycle sustained while the output is not stalled. The pipeline advances as a whole; a skid
// register behind the output catches the beat that leaves the pipeline as the output stalls.
// Synchronous active-high reset clears the valid bits only.
module great_circle_distance (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [30:0] req_first_latitude,
   input  logic signed [31:0] req_first_longitude,
   input  logic signed [30:0] req_second_latitude,
   input  logic signed [31:0] req_second_longitude,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [30:0]        rsp_distance_cm
);

   localparam int S      = gcd_pkg::CORDIC_STEPS;
   localparam int SB     = gcd_pkg::SQRT_BITS;
   localparam int NSTAGE = 8 + 2 * S + SB;

   // Magnitude of a CORDIC output; every such value stays well inside 32 bits.
   function automatic logic [31:0] mag32(input logic signed [gcd_pkg::CW-1:0] v);
      return 32'(v[gcd_pkg::CW-1] ? -v : v);
   endfunction

   // Product of two Q2.30 magnitudes, rounded half up.
   function automatic logic [32:0] mulq_mag(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b) + 64'd536870912;
      return 33'(p >> 30);
   endfunction

   // Pipeline control: everything moves together while the skid register is empty.
   logic                enable;
   logic [NSTAGE-1:0]   vld_ff;
   logic                skid_full_ff, skid_full_in;
   logic [30:0]         skid_ff, skid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [30:0]         rsp_dist_ff, rsp_dist_in;
   logic                tail_move, out_free;

   assign enable    = !skid_full_ff;
   assign req_stall = skid_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
      end
   end

   // Stage 0: the four angles in half units of 1e-7 degree. A plain difference is read as a
   // doubled half difference, and a doubled latitude gives the latitude itself for cosine.
   logic signed [gcd_pkg::DW-1:0] ang_ff [4];
   logic signed [gcd_pkg::DW-1:0] ang_in [4];

   always_comb begin
      ang_in[0] = gcd_pkg::DW'(req_second_latitude) - gcd_pkg::DW'(req_first_latitude);
      ang_in[1] = gcd_pkg::DW'(req_second_longitude) - gcd_pkg::DW'(req_first_longitude);
      ang_in[2] = gcd_pkg::DW'(req_first_latitude) <<< 1;
      ang_in[3] = gcd_pkg::DW'(req_second_latitude) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ang_ff <= ang_in;
      end
   end

   // Stages 1 to 3 fold and scale each angle; then a row of CORDIC_STEPS rotation cells per
   // angle gives sine in y and cosine in x. The fold negates both; only cosine signs are kept.
   logic signed [gcd_pkg::CW-1:0] rad [4];
   logic                          flip [4];
   gcd_pkg::cordic_vec_type       rot_vec [4][S+1];
   logic [S-1:0]                  flip1_ff, flip2_ff;

   for (genvar g = 0; g < 4; g++) begin : g_angle
      gcd_angle u_angle (
         .clock  (clock),
         .enable (enable),
         .angle  (ang_ff[g]),
         .rad    (rad[g]),
         .flip   (flip[g])
      );

      assign rot_vec[g][0] = '{x: gcd_pkg::CORDIC_GAIN, y: '0, z: rad[g]};

      for (genvar j = 0; j < S; j++) begin : g_cell
         gcd_cordic_cell u_cell (
            .clock    (clock),
            .enable   (enable),
            .mode     (gcd_pkg::CORDIC_ROTATE),
            .step     (gcd_pkg::STEP_W'(j)),
            .prev_vec (rot_vec[g][j]),
            .vec      (rot_vec[g][j+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         flip1_ff <= {flip1_ff[S-2:0], flip[2]};
         flip2_ff <= {flip2_ff[S-2:0], flip[3]};
      end
   end

   // First products: both squared sines and the cosine product, in sign and magnitude.
   logic [32:0] ps1_ff, ps1_in, ps2_ff, ps2_in, pc_mag_ff, pc_mag_in;
   logic        pc_neg_ff, pc_neg_in;

   always_comb begin
      ps1_in    = mulq_mag(mag32(rot_vec[0][S].y), mag32(rot_vec[0][S].y));
      ps2_in    = mulq_mag(mag32(rot_vec[1][S].y), mag32(rot_vec[1][S].y));
      pc_mag_in = mulq_mag(mag32(rot_vec[2][S].x), mag32(rot_vec[3][S].x));
      pc_neg_in = rot_vec[2][S].x[gcd_pkg::CW-1] ^ rot_vec[3][S].x[gcd_pkg::CW-1]
                  ^ flip1_ff[S-1] ^ flip2_ff[S-1];
   end

   // Second product, then the sum clamped to the closed unit interval.
   logic signed [33:0] pt_ff, pt_in;
   logic [32:0]        ps1b_ff;
   logic [32:0]        pt_mag;
   logic signed [34:0] a_sum;
   logic [30:0]        a_ff, a_in;

   always_comb begin
      pt_mag = mulq_mag(pc_mag_ff[31:0], ps2_ff[31:0]);
      pt_in  = pc_neg_ff ? -34'(pt_mag) : 34'(pt_mag);
      a_sum  = $signed(35'(ps1b_ff)) + 35'(pt_ff);
      if (a_sum[34]) begin
         a_in = '0;
      end else if (a_sum > $signed(35'(gcd_pkg::ONE_Q30))) begin
         a_in = gcd_pkg::ONE_Q30;
      end else begin
         a_in = 31'(a_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ps1_ff    <= ps1_in;
         ps2_ff    <= ps2_in;
         pc_mag_ff <= pc_mag_in;
         pc_neg_ff <= pc_neg_in;
         pt_ff     <= pt_in;
         ps1b_ff   <= ps1_ff;
         a_ff      <= a_in;
      end
   end

   // Two square-root rows, one root bit per cell, most significant first.
   gcd_pkg::sqrt_state_type sq_y [SB+1];
   gcd_pkg::sqrt_state_type sq_x [SB+1];

   assign sq_y[0] = '{rem: gcd_pkg::RW'(a_ff) << 30, root: '0};
   assign sq_x[0] = '{rem: gcd_pkg::RW'(gcd_pkg::ONE_Q30 - a_ff) << 30, root: '0};

   for (genvar k = 0; k < SB; k++) begin : g_sqrt
      gcd_sqrt_cell u_sqrt_y (
         .clock      (clock),
         .enable     (enable),
         .step       (gcd_pkg::SQRT_IW'(SB - 1 - k)),
         .prev_state (sq_y[k]),
         .state      (sq_y[k+1])
      );
      gcd_sqrt_cell u_sqrt_x (
         .clock      (clock),
         .enable     (enable),
         .step       (gcd_pkg::SQRT_IW'(SB - 1 - k)),
         .prev_state (sq_x[k]),
         .state      (sq_x[k+1])
      );
   end

   // Vectoring row: the angle of the point (sqrt(1-a), sqrt(a)) collects in z.
   gcd_pkg::cordic_vec_type vec [S+1];

   assign vec[0] = '{x: gcd_pkg::CW'(sq_x[SB].root), y: gcd_pkg::CW'(sq_y[SB].root), z: '0};

   for (genvar j = 0; j < S; j++) begin : g_vec
      gcd_cordic_cell u_cell (
         .clock    (clock),
         .enable   (enable),
         .mode     (gcd_pkg::CORDIC_VECTOR),
         .step     (gcd_pkg::STEP_W'(j)),
         .prev_vec (vec[j]),
         .vec      (vec[j+1])
      );
   end

   // Half the central angle, clamped to two radians, then scaled by the diameter in centimetres.
   logic [31:0] z_clamp;
   logic [62:0] dist_prod_ff, dist_prod_in;
   logic [31:0] dist_full;
   logic [30:0] dist_sat;

   always_comb begin
      if (vec[S].z[gcd_pkg::CW-1]) begin
         z_clamp = '0;
      end else if (vec[S].z > gcd_pkg::CW'(64'd2147483648)) begin
         z_clamp = 32'h8000_0000;
      end else begin
         z_clamp = 32'(vec[S].z);
      end
      dist_prod_in = 63'(z_clamp) * 63'(2 * gcd_pkg::RADIUS_CM);
      dist_full    = 32'((dist_prod_ff + 63'd536870912) >> 30);
      if (dist_full > 32'(gcd_pkg::HALF_CIRC_CM)) begin
         dist_sat = gcd_pkg::HALF_CIRC_CM[30:0];
      end else begin
         dist_sat = dist_full[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dist_prod_ff <= dist_prod_in;
      end
   end

   // Output register and skid register. A beat leaving the pipeline goes to the output when
   // that is free or being taken this cycle, and into the skid register otherwise.
   always_comb begin
      tail_move    = enable && vld_ff[NSTAGE-1];
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dist_in  = rsp_dist_ff;
      skid_full_in = skid_full_ff;
      skid_in      = skid_ff;
      if (skid_full_ff) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_dist_in  = skid_ff;
            skid_full_in = 1'b0;
         end
      end else if (tail_move) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_dist_in  = dist_sat;
         end else begin
            skid_full_in = 1'b1;
            skid_in      = dist_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      skid_ff     <= skid_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_cm = rsp_dist_ff;

`ifndef ASSERT_OFF
   // The skid register only fills behind a result that is waiting at the output.
   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> rsp_valid_ff)
      else $error("skid register holds a beat while the output is empty");

   // A beat leaving the pipeline into a stalled output must be caught by the skid register.
   a_tail_caught: assert property (@(posedge clock) disable iff (reset)
      (!skid_full_ff && vld_ff[NSTAGE-1] && rsp_valid_ff && rsp_stall) |=> skid_full_ff)
      else $error("beat left the pipeline with nowhere to go");

   // No distance ever exceeds half the circumference.
   a_distance_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_dist_ff) <= 32'(gcd_pkg::HALF_CIRC_CM)))
      else $error("distance beyond half circumference");
`endif

endmodule
